/* rtl/gasp_pkg.sv */
// Shared types and constants of the golden-angle spiral point generator.
// Used by every cell module and by the top level; depends on nothing else.
package gasp_pkg;

  localparam logic [31:0] GOLDEN_TURN = 32'h61C8_8647;
  localparam logic [31:0] INV_GAIN    = 32'd2608131496;

  localparam int DIV_STEPS  = 32;
  localparam int SQRT_STEPS = 16;
  localparam int ROT_STEPS  = 30;

  // Remainder width (point count is at most 2^16), vector and angle widths.
  localparam int RW = 17;
  localparam int VW = 36;
  localparam int ZW = 34;

  localparam logic [31:0] TURN_ATAN [ROT_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41721,
    32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
    32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
    32'd20, 32'd10, 32'd5, 32'd3, 32'd1
  };

  typedef struct packed {
    logic                 oor;
    logic [31:0]          ang;
    logic [RW-1:0]        rem;
    logic [31:0]          quo;
    logic [31:0]          sq_val;
    logic [32:0]          sq_res;
    logic                 flip;
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [ZW-1:0] z;
  } word_t;

endpackage

/* rtl/gasp_div_cell.sv */
// One restoring division step: one quotient bit of ((2i+1) << 31) / N.
// Depends on gasp_pkg.
module gasp_div_cell import gasp_pkg::*; #(
  parameter bit FIRST = 1'b0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [RW-1:0] count_i,
  input  word_t         prev_i,
  output word_t         word_o
);

  word_t         word_d;
  word_t         word_q;
  logic [RW:0]   trial;
  logic          qbit;

  always_comb begin
    word_d = prev_i;
    trial  = {prev_i.rem, FIRST};
    qbit   = (trial >= {1'b0, count_i});
    word_d.rem = qbit ? RW'(trial - {1'b0, count_i}) : trial[RW-1:0];
    word_d.quo = {prev_i.quo[30:0], qbit};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign word_o = word_q;

endmodule

/* rtl/gasp_sqrt_cell.sv */
// One digit of the integer square root of the 32-bit quotient.
// Depends on gasp_pkg.
module gasp_sqrt_cell import gasp_pkg::*; #(
  parameter int J     = 15,
  parameter bit FIRST = 1'b0
) (
  input  logic  clk_i,
  input  logic  en_i,
  input  word_t prev_i,
  output word_t word_o
);

  localparam logic [32:0] BIT = 33'd1 << (2 * J);

  word_t       word_d;
  word_t       word_q;
  logic [32:0] val;
  logic [32:0] res;
  logic [32:0] trial;

  always_comb begin
    word_d = prev_i;
    val    = FIRST ? {1'b0, prev_i.quo} : {1'b0, prev_i.sq_val};
    res    = FIRST ? 33'd0 : prev_i.sq_res;
    trial  = res + BIT;
    if (val >= trial) begin
      word_d.sq_val = 32'(val - trial);
      word_d.sq_res = (res >> 1) + BIT;
    end else begin
      word_d.sq_val = val[31:0];
      word_d.sq_res = res >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign word_o = word_q;

endmodule

/* rtl/gasp_rot_cell.sv */
// One CORDIC rotation step toward zero residual angle.
// Depends on gasp_pkg.
module gasp_rot_cell import gasp_pkg::*; #(
  parameter int K = 0
) (
  input  logic  clk_i,
  input  logic  en_i,
  input  word_t prev_i,
  output word_t word_o
);

  localparam logic signed [ZW-1:0] ATAN = ZW'(TURN_ATAN[K]);

  word_t                word_d;
  word_t                word_q;
  logic signed [VW-1:0] xs;
  logic signed [VW-1:0] ys;

  always_comb begin
    word_d = prev_i;
    xs     = prev_i.x >>> K;
    ys     = prev_i.y >>> K;
    if (!prev_i.z[ZW-1]) begin
      word_d.x = prev_i.x - ys;
      word_d.y = prev_i.y + xs;
      word_d.z = prev_i.z - ATAN;
    end else begin
      word_d.x = prev_i.x + ys;
      word_d.y = prev_i.y - xs;
      word_d.z = prev_i.z + ATAN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign word_o = word_q;

endmodule

/* rtl/golden_angle_spiral_point_top.sv */
// Golden-angle spiral point generator: one word in, one point out.
// An accepted index passes through the input stage, the cell chain and the output stage.
// Throughput is one word per cycle while the skid stage is empty, set by the chain
// of 32 divide, 16 root and 30 rotation cells that all advance together.
// Reset (rst_ni low, asynchronous) empties the chain and the skid stage and
// sets the point count to 65536. Depends on gasp_pkg and the cell modules.
module golden_angle_spiral_point_top import gasp_pkg::*; #(
  parameter int INDEX_BITS = 16,
  parameter int COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [RW-1:0]                cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [INDEX_BITS-1:0]        sample_index_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [COORD_BITS-1:0] x_coord_o,
  output logic signed [COORD_BITS-1:0] y_coord_o,
  output logic                         out_of_range_o
);

  // Stage map: 0 input, 1..32 divide, 33..48 root, 49 rotation setup,
  // 50..79 rotation, 80 rounding and saturation.
  localparam int DIV_BASE  = 1;
  localparam int SQRT_BASE = DIV_BASE + DIV_STEPS;
  localparam int PREP      = SQRT_BASE + SQRT_STEPS;
  localparam int ROT_BASE  = PREP + 1;
  localparam int LAST      = ROT_BASE + ROT_STEPS;
  localparam int NST       = LAST + 1;

  localparam logic signed [VW:0] RND = (VW+1)'(64'sd1 <<< (32 - COORD_BITS));
  localparam logic signed [VW:0] HI  = (VW+1)'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [VW:0] LO  = (VW+1)'(-(64'sd1 <<< (COORD_BITS - 1)));

  function automatic logic signed [COORD_BITS-1:0] to_coord(logic signed [VW-1:0] v);
    logic signed [VW:0] s;
    s = ($signed({v[VW-1], v}) + RND) >>> (33 - COORD_BITS);
    if (s > HI) begin
      s = HI;
    end else if (s < LO) begin
      s = LO;
    end
    return s[COORD_BITS-1:0];
  endfunction

  logic [RW-1:0] count_q;
  logic [NST-1:0] valid_q;
  logic           skid_q;
  logic           adv;

  word_t w [LAST];
  word_t in_d;
  word_t prep_d;
  logic [31:0] idx_ext;
  logic [31:0] turned;

  logic signed [COORD_BITS-1:0] x_q, y_q, skid_x_q, skid_y_q;
  logic                         oor_q, skid_oor_q;

  // The whole chain moves together; it holds only while the skid stage is
  // full, so a word is still taken while one finished point waits.
  assign adv        = !skid_q;
  assign in_stall_o = skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= RW'(65536);
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      skid_q  <= 1'b0;
    end else begin
      if (adv) begin
        valid_q <= {valid_q[NST-2:0], in_valid_i};
      end
      skid_q <= skid_q ? out_stall_i : (valid_q[LAST] && out_stall_i);
    end
  end

  // Input stage: range check, angle product, and the top remainder of the
  // dividend, which is the index itself.
  always_comb begin
    idx_ext     = 32'(sample_index_i);
    in_d        = '0;
    in_d.oor    = (idx_ext >= 32'(count_q));
    in_d.ang    = 32'(idx_ext * GOLDEN_TURN);
    in_d.rem    = idx_ext[RW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      w[0] <= in_d;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    gasp_div_cell #(.FIRST(k == 0)) u_cell (
      .clk_i   (clk_i),
      .en_i    (adv),
      .count_i (count_q),
      .prev_i  (w[DIV_BASE + k - 1]),
      .word_o  (w[DIV_BASE + k])
    );
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    gasp_sqrt_cell #(.J(SQRT_STEPS - 1 - k), .FIRST(k == 0)) u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .prev_i (w[SQRT_BASE + k - 1]),
      .word_o (w[SQRT_BASE + k])
    );
  end

  // Rotation setup: scale the radius by the inverse CORDIC gain and fold
  // angles past a quarter turn by a half turn, negating the result later.
  always_comb begin
    prep_d      = w[PREP - 1];
    prep_d.flip = turned[31];
    prep_d.z    = ZW'($signed(w[PREP - 1].ang ^ {turned[31], 31'b0}));
    prep_d.x    = VW'(48'(w[PREP - 1].sq_res[15:0] * INV_GAIN) >> 16);
    prep_d.y    = '0;
  end
  assign turned = w[PREP - 1].ang + 32'h4000_0000;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      w[PREP] <= prep_d;
    end
  end

  for (genvar k = 0; k < ROT_STEPS; k++) begin : g_rot
    gasp_rot_cell #(.K(k)) u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .prev_i (w[ROT_BASE + k - 1]),
      .word_o (w[ROT_BASE + k])
    );
  end

  // Output stage and a one-word skid stage that catches the point when the
  // chain moves while the consumer stalls.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      oor_q <= w[LAST - 1].oor;
      if (w[LAST - 1].oor) begin
        x_q <= '0;
        y_q <= '0;
      end else if (w[LAST - 1].flip) begin
        x_q <= to_coord(-w[LAST - 1].x);
        y_q <= to_coord(-w[LAST - 1].y);
      end else begin
        x_q <= to_coord(w[LAST - 1].x);
        y_q <= to_coord(w[LAST - 1].y);
      end
    end
    if (!skid_q) begin
      skid_x_q   <= x_q;
      skid_y_q   <= y_q;
      skid_oor_q <= oor_q;
    end
  end

  assign out_valid_o    = skid_q || valid_q[LAST];
  assign x_coord_o      = skid_q ? skid_x_q : x_q;
  assign y_coord_o      = skid_q ? skid_y_q : y_q;
  assign out_of_range_o = skid_q ? skid_oor_q : oor_q;

endmodule

/* rtl/gasp_checker.sv */
// Port-level checks of the spiral point generator, bound to its top level.
// Depends on golden_angle_spiral_point_top.
module gasp_checker #(
  parameter int COORD_BITS = 16
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic signed [COORD_BITS-1:0] x_coord_o,
  input logic signed [COORD_BITS-1:0] y_coord_o,
  input logic                         out_of_range_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(x_coord_o) && $stable(y_coord_o))
    else $error("stalled output word changed");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |-> x_coord_o == '0 && y_coord_o == '0)
    else $error("out-of-range point has nonzero coordinates");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without a stalled output");

endmodule

bind golden_angle_spiral_point_top gasp_checker #(
  .COORD_BITS(COORD_BITS)
) u_gasp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .x_coord_o      (x_coord_o),
  .y_coord_o      (y_coord_o),
  .out_of_range_o (out_of_range_o)
);
